@@ src/lsd_pkg.sv @@
// Shared types and constants of the LIFO stack with dump.
package lsd_pkg;

  localparam int DATA_W = 32;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_DUMP  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] DSEL_ZERO = 2'd0;
  localparam logic [1:0] DSEL_VAL  = 2'd1;
  localparam logic [1:0] DSEL_RAM  = 2'd2;

  typedef struct packed {
    logic       in_ready;
    logic       ram_wr;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       cnt_clr;
    logic       rd_first;
    logic       rd_next;
    logic       load;
    logic [1:0] res_status;
    logic [1:0] res_dsel;
    logic       res_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] cmd;
    logic       empty;
    logic       full;
    logic       ptr_zero;
    logic       slot_free;
  } ctl_stat_t;

endpackage

@@ src/lsd_if.sv @@
// Valid/ready channel interfaces for command words and result words.
interface lsd_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [31:0] push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink (input valid, input command, input push_value, output ready);
endinterface

interface lsd_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [31:0] data_value;
  logic              last_of_run;

  modport source (output valid, output status, output data_value, output last_of_run,
                  input ready);
  modport sink (input valid, input status, input data_value, input last_of_run,
                output ready);
endinterface

@@ src/lifo_stack_with_dump.sv @@
// Top level of the LIFO stack with dump.
// A command word is registered when taken in IDLE and executed in EXEC; push, clear
// and a pop or dump of an empty stack finish there, else READ emits the entries read,
// one entry read and emitted per cycle while the output register is free.
// A result word not yet taken holds the controller until the output register frees.
// Synchronous reset empties the stack and drops any pending result word.
module lifo_stack_with_dump #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  lsd_req_if.sink   req,
  lsd_rsp_if.source rsp
);
  import lsd_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  lsd_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .stat(stat),
    .cmd (cmd)
  );

  lsd_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .stat(stat)
  );

endmodule

@@ src/lsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/lsd_ctrl.sv @@
// Controller state machine that sequences each command word.
module lsd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  lsd_pkg::ctl_stat_t stat,
  output lsd_pkg::ctl_cmd_t  cmd
);
  import lsd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.cmd)
          CMD_PUSH: begin
            if (stat.slot_free) begin
              cmd.load     = 1'b1;
              cmd.res_last = 1'b1;
              if (stat.full) begin
                cmd.res_status = ST_FULL;
                cmd.res_dsel   = DSEL_ZERO;
              end else begin
                cmd.ram_wr     = 1'b1;
                cmd.cnt_inc    = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_dsel   = DSEL_VAL;
              end
              state_next = S_IDLE;
            end
          end
          CMD_CLEAR: begin
            if (stat.slot_free) begin
              cmd.load       = 1'b1;
              cmd.res_last   = 1'b1;
              cmd.res_dsel   = DSEL_ZERO;
              cmd.res_status = stat.empty ? ST_EMPTY : ST_OK;
              cmd.cnt_clr    = 1'b1;
              state_next     = S_IDLE;
            end
          end
          CMD_POP, CMD_DUMP: begin
            if (stat.empty) begin
              if (stat.slot_free) begin
                cmd.load       = 1'b1;
                cmd.res_last   = 1'b1;
                cmd.res_status = ST_EMPTY;
                cmd.res_dsel   = DSEL_ZERO;
                state_next     = S_IDLE;
              end
            end else begin
              cmd.rd_first = 1'b1;
              cmd.cnt_dec  = (stat.cmd == CMD_POP);
              state_next   = S_READ;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_READ: begin
        if (stat.slot_free) begin
          cmd.load       = 1'b1;
          cmd.res_status = ST_OK;
          cmd.res_dsel   = DSEL_RAM;
          cmd.res_last   = (stat.cmd == CMD_POP) || stat.ptr_zero;
          if (cmd.res_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_read_only_for_pop_dump: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (stat.cmd == CMD_POP || stat.cmd == CMD_DUMP))
    else $error("read state entered for a command that reads nothing");
  a_no_read_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_first |-> !stat.empty)
    else $error("stack read issued while empty");
  a_single_count_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.cnt_inc, cmd.cnt_dec, cmd.cnt_clr}))
    else $error("more than one fill count update in a cycle");
`endif

endmodule

@@ src/lsd_dp.sv @@
// Datapath: fill count, entry memory, dump pointer and result register.
module lsd_dp #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  lsd_req_if.sink            req,
  lsd_rsp_if.source          rsp,
  input  lsd_pkg::ctl_cmd_t  cmd,
  output lsd_pkg::ctl_stat_t stat
);
  import lsd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]        cmd_q;
  logic [DATA_W-1:0] val_q;
  logic [CW-1:0]     count;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     top_addr;
  logic [DATA_W-1:0] rdata;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [DATA_W-1:0] out_data;
  logic              out_last;
  logic              full;
  logic              slot_free;

  assign full      = (count == CW'(DEPTH));
  assign slot_free = !out_valid || rsp.ready;
  assign top_addr  = AW'(count - CW'(1));
  assign raddr     = cmd.rd_first ? top_addr : (ptr - AW'(1));

  assign stat.in_valid  = req.valid;
  assign stat.cmd       = cmd_q;
  assign stat.empty     = (count == '0);
  assign stat.full      = full;
  assign stat.ptr_zero  = (ptr == '0);
  assign stat.slot_free = slot_free;

  assign req.ready       = cmd.in_ready;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.data_value  = out_data;
  assign rsp.last_of_run = out_last;

  lsd_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.ram_wr),
    .waddr(count[AW-1:0]),
    .wdata(val_q),
    .re   (cmd.rd_first || cmd.rd_next),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.in_ready && req.valid) begin
      cmd_q <= req.command;
      val_q <= req.push_value;
    end
    if (cmd.rd_first || cmd.rd_next) begin
      ptr <= raddr;
    end
    if (cmd.load) begin
      out_status <= cmd.res_status;
      out_last   <= cmd.res_last;
      unique case (cmd.res_dsel)
        DSEL_VAL: out_data <= val_q;
        DSEL_RAM: out_data <= rdata;
        default:  out_data <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      priority if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.cnt_inc) begin
        count <= count + CW'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CW'(1);
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count beyond depth");
  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ram_wr |-> !full)
    else $error("entry written while stack full");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> slot_free)
    else $error("result register overwritten before its word was taken");
`endif

endmodule
